// ===== src/srt_pkg.sv =====
`timescale 1ns / 1ps

package srt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int PORT_W = 16;
  localparam int ADDR_W = 32;
  localparam int REF_W  = 31;
  localparam int SLOT_W = 4;
  localparam int KEY_W  = PORT_W + ADDR_W;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] address;
    logic [REF_W-1:0]  ref_num;
  } entry_t;

endpackage

// ===== src/srt_table.sv =====
`timescale 1ns / 1ps

module srt_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [srt_pkg::IDX_W-1:0] rd_idx,
  input  logic                     wr_en,
  input  logic [srt_pkg::IDX_W-1:0] wr_idx,
  input  srt_pkg::entry_t          wr_data,
  output logic                     q_valid,
  output srt_pkg::entry_t          q_data
);

  srt_pkg::entry_t                    mem [srt_pkg::TABLE_ENTRIES];
  logic [srt_pkg::TABLE_ENTRIES-1:0]  valid_r;
  logic                               q_valid_r;
  srt_pkg::entry_t                    q_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      q_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        q_valid_r <= valid_r[rd_idx];
      end
    end
  end

  assign q_valid = q_valid_r;
  assign q_data  = q_data_r;

endmodule

// ===== src/source_record_table.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// in_       in_valid / in_stall  in_func, in_port, in_address, in_ref_req
// out_      out_valid / out_stall out_found, out_inserted, out_full_error,
//                                out_slot, out_ref, out_port, out_address
//
// One request is handled by a scan: one table entry is read per cycle
// through the single read port and checked by one shared key comparator,
// then the finish state hands the result on. A hit ends the scan early.
// Reset clears every valid bit at once; no clearing pass.
// in_stall is high from acceptance until the result is in the output
// register; a held result does not block the next request.

module source_record_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [srt_pkg::PORT_W-1:0]  in_port,
  input  logic [srt_pkg::ADDR_W-1:0]  in_address,
  input  logic [srt_pkg::REF_W-1:0]   in_ref_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic                        out_inserted,
  output logic                        out_full_error,
  output logic [srt_pkg::SLOT_W-1:0]  out_slot,
  output logic [srt_pkg::REF_W-1:0]   out_ref,
  output logic [srt_pkg::PORT_W-1:0]  out_port,
  output logic [srt_pkg::ADDR_W-1:0]  out_address
);

  localparam logic [srt_pkg::CNT_W-1:0] CNT_END = srt_pkg::CNT_W'(srt_pkg::TABLE_ENTRIES);
  localparam logic [srt_pkg::IDX_W-1:0] IDX_LAST =
    srt_pkg::IDX_W'(srt_pkg::TABLE_ENTRIES - 1);

  srt_pkg::state_t state_r, state_nxt;

  logic                        func_r, func_nxt;
  srt_pkg::entry_t             req_r, req_nxt;
  logic [srt_pkg::CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [srt_pkg::IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic                        have_free_r, have_free_nxt;
  logic [srt_pkg::IDX_W-1:0]   free_idx_r, free_idx_nxt;

  logic                        pend_found_r, pend_found_nxt;
  logic                        pend_ins_r, pend_ins_nxt;
  logic                        pend_full_r, pend_full_nxt;
  logic [srt_pkg::IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  srt_pkg::entry_t             pend_entry_r, pend_entry_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_inserted_r, out_full_r;
  logic [srt_pkg::SLOT_W-1:0]  out_slot_r;
  srt_pkg::entry_t             out_entry_r;

  logic                        accept;
  logic                        rd_en;
  logic                        out_load;
  logic                        wr_en;
  logic                        q_valid;
  srt_pkg::entry_t             q_data;

  logic [srt_pkg::KEY_W-1:0]   key_req;
  logic [srt_pkg::KEY_W-1:0]   key_entry;
  logic                        key_hit;
  logic                        free_here;
  logic                        any_free;
  logic [srt_pkg::IDX_W-1:0]   free_now;
  logic                        scan_last;
  logic                        scan_done;

  srt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx_r[srt_pkg::IDX_W-1:0]),
    .wr_en   (wr_en),
    .wr_idx  (pend_idx_r),
    .wr_data (pend_entry_r),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  // shared comparator: port/address for record, reference for find
  always_comb begin
    if (func_r == srt_pkg::FUNC_FIND) begin
      key_req   = srt_pkg::KEY_W'(req_r.ref_num);
      key_entry = srt_pkg::KEY_W'(q_data.ref_num);
    end else begin
      key_req   = {req_r.port, req_r.address};
      key_entry = {q_data.port, q_data.address};
    end
    key_hit   = cmp_vld_r && q_valid && (key_req == key_entry);
    free_here = cmp_vld_r && !q_valid && (func_r == srt_pkg::FUNC_RECORD);
    any_free  = free_here || have_free_r;
    free_now  = free_here ? cmp_idx_r : free_idx_r;
    scan_last = cmp_vld_r && (cmp_idx_r == IDX_LAST);
    scan_done = key_hit || scan_last;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srt_pkg::ST_IDLE: if (in_valid) state_nxt = srt_pkg::ST_SCAN;
      srt_pkg::ST_SCAN: if (scan_done) state_nxt = srt_pkg::ST_FIN;
      srt_pkg::ST_FIN:  if (out_load) state_nxt = srt_pkg::ST_IDLE;
      default:          state_nxt = srt_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      srt_pkg::ST_IDLE: in_stall = 1'b0;
      srt_pkg::ST_SCAN: rd_en = (rd_idx_r != CNT_END);
      srt_pkg::ST_FIN:  out_load = !out_valid_r || !out_stall;
      default:          in_stall = 1'b1;
    endcase
    accept = in_valid && !in_stall;
    wr_en  = out_load && pend_ins_r;
  end

  // datapath
  always_comb begin
    func_nxt       = func_r;
    req_nxt        = req_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    have_free_nxt  = have_free_r;
    free_idx_nxt   = free_idx_r;
    pend_found_nxt = pend_found_r;
    pend_ins_nxt   = pend_ins_r;
    pend_full_nxt  = pend_full_r;
    pend_idx_nxt   = pend_idx_r;
    pend_entry_nxt = pend_entry_r;

    if (accept) begin
      func_nxt         = in_func;
      req_nxt.port     = in_port;
      req_nxt.address  = in_address;
      req_nxt.ref_num  = in_ref_req;
      rd_idx_nxt       = '0;
      cmp_vld_nxt      = 1'b0;
      have_free_nxt    = 1'b0;
    end

    if (state_r == srt_pkg::ST_SCAN) begin
      cmp_vld_nxt = rd_en;
      cmp_idx_nxt = rd_idx_r[srt_pkg::IDX_W-1:0];
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
      if (free_here) begin
        have_free_nxt = 1'b1;
        free_idx_nxt  = cmp_idx_r;
      end
      if (scan_done) begin
        pend_found_nxt = key_hit;
        pend_ins_nxt   = !key_hit && (func_r == srt_pkg::FUNC_RECORD) && any_free;
        pend_full_nxt  = !key_hit && (func_r == srt_pkg::FUNC_RECORD) && !any_free;
        if (key_hit) begin
          pend_idx_nxt   = cmp_idx_r;
          pend_entry_nxt = q_data;
        end else begin
          pend_idx_nxt   = free_now;
          pend_entry_nxt = req_r;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    req_r        <= req_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    have_free_r  <= have_free_nxt;
    free_idx_r   <= free_idx_nxt;
    pend_found_r <= pend_found_nxt;
    pend_ins_r   <= pend_ins_nxt;
    pend_full_r  <= pend_full_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_entry_r <= pend_entry_nxt;
    if (out_load) begin
      out_found_r    <= pend_found_r;
      out_inserted_r <= pend_ins_r;
      out_full_r     <= pend_full_r;
      if (pend_found_r || pend_ins_r) begin
        out_slot_r  <= srt_pkg::SLOT_W'(pend_idx_r);
        out_entry_r <= pend_entry_r;
      end else begin
        out_slot_r  <= '0;
        out_entry_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_inserted   = out_inserted_r;
  assign out_full_error = out_full_r;
  assign out_slot       = out_slot_r;
  assign out_ref        = out_entry_r.ref_num;
  assign out_port       = out_entry_r.port;
  assign out_address    = out_entry_r.address;

endmodule

// ===== tb/sv/source_record_table_chk.sv =====
`timescale 1ns / 1ps

module source_record_table_chk (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_func,
  input  logic [srt_pkg::PORT_W-1:0] in_port,
  input  logic [srt_pkg::ADDR_W-1:0] in_address,
  input  logic [srt_pkg::REF_W-1:0]  in_ref_req,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_found,
  input  logic                       out_inserted,
  input  logic                       out_full_error,
  input  logic [srt_pkg::SLOT_W-1:0] out_slot,
  input  logic [srt_pkg::REF_W-1:0]  out_ref,
  input  logic [srt_pkg::PORT_W-1:0] out_port,
  input  logic [srt_pkg::ADDR_W-1:0] out_address,
  output int                         pending,
  output int                         errors
);

  typedef struct {
    logic                       found;
    logic                       inserted;
    logic                       full_error;
    logic [srt_pkg::SLOT_W-1:0] slot;
    logic [srt_pkg::REF_W-1:0]  ref_num;
    logic [srt_pkg::PORT_W-1:0] port;
    logic [srt_pkg::ADDR_W-1:0] address;
  } table_result_t;

  logic                       src_valid [srt_pkg::TABLE_ENTRIES];
  logic [srt_pkg::PORT_W-1:0] src_port  [srt_pkg::TABLE_ENTRIES];
  logic [srt_pkg::ADDR_W-1:0] src_addr  [srt_pkg::TABLE_ENTRIES];
  logic [srt_pkg::REF_W-1:0]  src_ref   [srt_pkg::TABLE_ENTRIES];

  table_result_t expected_q[$];

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic table_result_t entry_result(input logic fnd, input logic ins,
                                                 input logic full, input int idx);
    table_result_t res;
    res.found      = fnd;
    res.inserted   = ins;
    res.full_error = full;
    if (idx >= 0) begin
      res.slot    = srt_pkg::SLOT_W'(idx);
      res.ref_num = src_ref[idx];
      res.port    = src_port[idx];
      res.address = src_addr[idx];
    end else begin
      res.slot    = '0;
      res.ref_num = '0;
      res.port    = '0;
      res.address = '0;
    end
    return res;
  endfunction

  // Updates the shadow table and returns the expected response.
  function automatic table_result_t apply_request(input logic func,
                                                  input logic [srt_pkg::PORT_W-1:0] port,
                                                  input logic [srt_pkg::ADDR_W-1:0] addr,
                                                  input logic [srt_pkg::REF_W-1:0] ref_num);
    int free_idx;
    free_idx = -1;
    if (func == srt_pkg::FUNC_FIND) begin
      for (int i = 0; i < srt_pkg::TABLE_ENTRIES; i++)
        if (src_valid[i] && src_ref[i] == ref_num)
          return entry_result(1'b1, 1'b0, 1'b0, i);
      return entry_result(1'b0, 1'b0, 1'b0, -1);
    end
    for (int i = 0; i < srt_pkg::TABLE_ENTRIES; i++) begin
      if (!src_valid[i]) begin
        free_idx = i;
      end else if (src_port[i] == port && src_addr[i] == addr) begin
        return entry_result(1'b1, 1'b0, 1'b0, i);
      end
    end
    if (free_idx < 0) return entry_result(1'b0, 1'b0, 1'b1, -1);
    src_valid[free_idx] = 1'b1;
    src_port[free_idx]  = port;
    src_addr[free_idx]  = addr;
    src_ref[free_idx]   = ref_num;
    return entry_result(1'b0, 1'b1, 1'b0, free_idx);
  endfunction

  task automatic check_field(input string name, input logic [srt_pkg::ADDR_W-1:0] want,
                             input logic [srt_pkg::ADDR_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                 $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < srt_pkg::TABLE_ENTRIES; i++) src_valid[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: response with no request outstanding", $realtime);
        end else begin
          want = expected_q.pop_front();
          check_field("found",       srt_pkg::ADDR_W'(want.found),
                      srt_pkg::ADDR_W'(out_found));
          check_field("inserted",    srt_pkg::ADDR_W'(want.inserted),
                      srt_pkg::ADDR_W'(out_inserted));
          check_field("full_error",  srt_pkg::ADDR_W'(want.full_error),
                      srt_pkg::ADDR_W'(out_full_error));
          check_field("slot",        srt_pkg::ADDR_W'(want.slot),
                      srt_pkg::ADDR_W'(out_slot));
          check_field("out_ref",     srt_pkg::ADDR_W'(want.ref_num),
                      srt_pkg::ADDR_W'(out_ref));
          check_field("out_port",    srt_pkg::ADDR_W'(want.port),
                      srt_pkg::ADDR_W'(out_port));
          check_field("out_address", want.address, out_address);
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(apply_request(in_func, in_port, in_address, in_ref_req));
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/sv/source_record_table_tb.sv =====
`timescale 1ns / 1ps

module source_record_table_tb;

  localparam int N_RANDOM   = 1240;
  localparam int N_KEYS     = 24;
  localparam int N_REFS     = 12;
  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 2000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_func;
  logic [srt_pkg::PORT_W-1:0] in_port;
  logic [srt_pkg::ADDR_W-1:0] in_address;
  logic [srt_pkg::REF_W-1:0]  in_ref_req;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_found;
  logic                       out_inserted;
  logic                       out_full_error;
  logic [srt_pkg::SLOT_W-1:0] out_slot;
  logic [srt_pkg::REF_W-1:0]  out_ref;
  logic [srt_pkg::PORT_W-1:0] out_port;
  logic [srt_pkg::ADDR_W-1:0] out_address;

  int   pending;
  int   errors;
  int   idle_cycles;
  logic quiet;
  logic hold_long_req;

  logic [srt_pkg::PORT_W-1:0] key_port [N_KEYS];
  logic [srt_pkg::ADDR_W-1:0] key_addr [N_KEYS];
  logic [srt_pkg::REF_W-1:0]  ref_pool [N_REFS];

  source_record_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_port        (in_port),
    .in_address     (in_address),
    .in_ref_req     (in_ref_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_inserted   (out_inserted),
    .out_full_error (out_full_error),
    .out_slot       (out_slot),
    .out_ref        (out_ref),
    .out_port       (out_port),
    .out_address    (out_address)
  );

  source_record_table_chk i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_port        (in_port),
    .in_address     (in_address),
    .in_ref_req     (in_ref_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_inserted   (out_inserted),
    .out_full_error (out_full_error),
    .out_slot       (out_slot),
    .out_ref        (out_ref),
    .out_port       (out_port),
    .out_address    (out_address),
    .pending        (pending),
    .errors         (errors)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Response side: short random stalls, one long hold to back up the table.
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_long_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer_req(input logic func, input logic [srt_pkg::PORT_W-1:0] port,
                           input logic [srt_pkg::ADDR_W-1:0] addr,
                           input logic [srt_pkg::REF_W-1:0] ref_num);
    in_valid   <= 1'b1;
    in_func    <= func;
    in_port    <= port;
    in_address <= addr;
    in_ref_req <= ref_num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int                         kind;
    int                         k;
    logic                       func;
    logic [srt_pkg::PORT_W-1:0] port;
    logic [srt_pkg::ADDR_W-1:0] addr;
    logic [srt_pkg::REF_W-1:0]  ref_num;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = srt_pkg::FUNC_RECORD;
    in_port       = '0;
    in_address    = '0;
    in_ref_req    = '0;
    quiet         = 1'b0;
    hold_long_req = 1'b0;
    idle_cycles   = 0;

    // odd keys share the port of their neighbor so partial matches occur
    for (int i = 0; i < N_KEYS; i++) begin
      key_port[i] = (i % 2 == 1) ? key_port[i-1] : srt_pkg::PORT_W'($urandom);
      key_addr[i] = (i % 4 == 3) ? key_addr[i-2] : $urandom;
    end
    ref_pool[0] = '0;
    ref_pool[1] = '1;
    for (int i = 2; i < N_REFS; i++)
      ref_pool[i] = (i < 6) ? srt_pkg::REF_W'(i) : srt_pkg::REF_W'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-table finds, extreme keys, record hit, duplicate refs
    offer_req(srt_pkg::FUNC_FIND,   '0, '0, '0);
    offer_req(srt_pkg::FUNC_FIND,   '1, '1, '1);
    offer_req(srt_pkg::FUNC_RECORD, '0, '0, '0);
    offer_req(srt_pkg::FUNC_RECORD, '1, '1, '1);
    offer_req(srt_pkg::FUNC_RECORD, '0, '0, srt_pkg::REF_W'(123));
    offer_req(srt_pkg::FUNC_RECORD, '0, '1, srt_pkg::REF_W'(5));
    offer_req(srt_pkg::FUNC_RECORD, '1, '0, srt_pkg::REF_W'(5));
    offer_req(srt_pkg::FUNC_FIND,   '0, '0, srt_pkg::REF_W'(5));
    offer_req(srt_pkg::FUNC_FIND,   '1, '1, '0);
    offer_req(srt_pkg::FUNC_FIND,   '0, '0, '1);
    offer_req(srt_pkg::FUNC_FIND,   '0, '0, srt_pkg::REF_W'(6));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_long_req <= 1'b1;
      if (n == N_RANDOM - 180) quiet <= 1'b1;
      if (n == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end

      kind = $urandom_range(0, 99);
      k    = $urandom_range(0, N_KEYS - 1);
      if (kind < 45) begin
        func    = srt_pkg::FUNC_RECORD;
        port    = key_port[k];
        addr    = key_addr[k];
        ref_num = ($urandom_range(0, 3) == 0) ? srt_pkg::REF_W'($urandom)
                                              : ref_pool[$urandom_range(0, N_REFS - 1)];
      end else if (kind < 80) begin
        func    = srt_pkg::FUNC_FIND;
        port    = srt_pkg::PORT_W'($urandom);
        addr    = $urandom;
        ref_num = ref_pool[$urandom_range(0, N_REFS - 1)];
      end else begin
        func    = ($urandom_range(0, 1) == 0) ? srt_pkg::FUNC_RECORD : srt_pkg::FUNC_FIND;
        port    = srt_pkg::PORT_W'($urandom);
        addr    = $urandom;
        ref_num = srt_pkg::REF_W'($urandom);
      end
      offer_req(func, port, addr, ref_num);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/srt_pkg.sv
src/srt_table.sv
src/source_record_table.sv
tb/sv/source_record_table_chk.sv
tb/sv/source_record_table_tb.sv
